/* src/sat_pkg.sv */
// shared types and constants for the sorted array table
package sat_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int CMD_W     = 2;
    localparam int IDX_W     = 8;
    localparam int STATUS_W  = 2;
    localparam int CAP_W     = 9;
    localparam int CNT_OUT_W = 9;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_COUNT,
        PTR_INDEX,
        PTR_DEC,
        PTR_INC
    } ptr_op_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_COUNT_M1,
        RD_PTR_M2,
        RD_PTR_P2,
        RD_INDEX,
        RD_INDEX_P1
    } rd_sel_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef struct packed {
        logic                latch;
        ptr_op_t             ptr_op;
        rd_sel_t             rd_sel;
        logic                wr_en;
        logic                wr_item;
        cnt_op_t             cnt_op;
        logic                respond;
        logic [STATUS_W-1:0] resp_status;
        logic                resp_value;
    } ctrl_t;

    typedef struct packed {
        logic full;
        logic idx_bad;
        logic idx_last;
        logic empty;
        logic data_ge;
        logic ptr_is_one;
        logic rem_more;
    } stat_t;

endpackage

/* src/sat_ram.sv */
// generic single write port ram with registered read
module sat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/sat_ctrl.sv */
// command sequencer for the sorted array table
module sat_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [sat_pkg::CMD_W-1:0]  command,
    input  sat_pkg::stat_t             stat,
    output sat_pkg::ctrl_t             ctrl,
    output logic                       busy
);

    import sat_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SHIFT,
        S_INS_LAST,
        S_LK_WAIT,
        S_REM_SHIFT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        ctrl             = '0;
        ctrl.ptr_op      = PTR_HOLD;
        ctrl.rd_sel      = RD_NONE;
        ctrl.cnt_op      = CNT_HOLD;
        ctrl.resp_status = ST_DONE;
        state_next       = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.latch = 1'b1;
                    case (command)
                        CMD_INSERT:
                        begin
                            if (stat.full)
                            begin
                                ctrl.respond     = 1'b1;
                                ctrl.resp_status = ST_FULL;
                            end
                            else if (stat.empty)
                            begin
                                ctrl.ptr_op = PTR_COUNT;
                                state_next  = S_INS_LAST;
                            end
                            else
                            begin
                                ctrl.ptr_op = PTR_COUNT;
                                ctrl.rd_sel = RD_COUNT_M1;
                                state_next  = S_INS_SHIFT;
                            end
                        end
                        CMD_LOOKUP:
                        begin
                            if (stat.idx_bad)
                            begin
                                ctrl.respond     = 1'b1;
                                ctrl.resp_status = ST_BAD_INDEX;
                            end
                            else
                            begin
                                ctrl.rd_sel = RD_INDEX;
                                state_next  = S_LK_WAIT;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (stat.idx_bad)
                            begin
                                ctrl.respond     = 1'b1;
                                ctrl.resp_status = ST_BAD_INDEX;
                            end
                            else if (stat.idx_last)
                            begin
                                ctrl.cnt_op  = CNT_DEC;
                                ctrl.respond = 1'b1;
                            end
                            else
                            begin
                                ctrl.ptr_op = PTR_INDEX;
                                ctrl.rd_sel = RD_INDEX_P1;
                                state_next  = S_REM_SHIFT;
                            end
                        end
                        default:
                        begin
                            ctrl.respond = 1'b1;
                        end
                    endcase
                end
            end
            S_INS_SHIFT:
            begin
                ctrl.wr_en = 1'b1;
                if (stat.data_ge)
                begin
                    ctrl.ptr_op = PTR_DEC;
                    if (stat.ptr_is_one)
                    begin
                        state_next = S_INS_LAST;
                    end
                    else
                    begin
                        ctrl.rd_sel = RD_PTR_M2;
                    end
                end
                else
                begin
                    ctrl.wr_item = 1'b1;
                    ctrl.cnt_op  = CNT_INC;
                    ctrl.respond = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_INS_LAST:
            begin
                ctrl.wr_en   = 1'b1;
                ctrl.wr_item = 1'b1;
                ctrl.cnt_op  = CNT_INC;
                ctrl.respond = 1'b1;
                state_next   = S_IDLE;
            end
            S_LK_WAIT:
            begin
                ctrl.respond    = 1'b1;
                ctrl.resp_value = 1'b1;
                state_next      = S_IDLE;
            end
            S_REM_SHIFT:
            begin
                ctrl.wr_en  = 1'b1;
                ctrl.ptr_op = PTR_INC;
                if (stat.rem_more)
                begin
                    ctrl.rd_sel = RD_PTR_P2;
                end
                else
                begin
                    ctrl.cnt_op  = CNT_DEC;
                    ctrl.respond = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

/* src/sat_datapath.sv */
// table memory, count, pointer and result registers
module sat_datapath #(
    parameter int TABLE_DEPTH = sat_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = sat_pkg::VALUE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [sat_pkg::CAP_W-1:0]      cfg_wr_data,
    input  logic [VALUE_WIDTH-1:0]         item_value,
    input  logic [sat_pkg::IDX_W-1:0]      entry_index,
    input  sat_pkg::ctrl_t                 ctrl,
    output sat_pkg::stat_t                 stat,
    output logic                           done,
    output logic [VALUE_WIDTH-1:0]         read_value,
    output logic [sat_pkg::STATUS_W-1:0]   status,
    output logic [sat_pkg::CNT_OUT_W-1:0]  entry_count
);

    import sat_pkg::*;

    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

    logic [CAP_W-1:0]       cap_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic [CW-1:0]          ptr_reg;
    logic [CW-1:0]          ptr_next;
    logic [VALUE_WIDTH-1:0] item_reg;
    logic                   done_reg;
    logic [VALUE_WIDTH-1:0] read_value_reg;
    logic [STATUS_W-1:0]    status_reg;

    logic [CW-1:0]          idx_cw;
    logic [CMPW-1:0]        idx_ext;
    logic [CMPW-1:0]        count_ext;
    logic [CMPW-1:0]        cap_ext;
    logic [CMPW-1:0]        cap_eff;
    logic [CMPW-1:0]        depth_ext;
    logic [CW-1:0]          rd_ptr;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [AW-1:0]          ram_waddr;
    logic [VALUE_WIDTH-1:0] ram_wdata;
    logic [VALUE_WIDTH-1:0] ram_rdata;

    assign idx_cw    = CW'(entry_index);
    assign idx_ext   = CMPW'(entry_index);
    assign count_ext = CMPW'(count_reg);
    assign cap_ext   = CMPW'(cap_reg);
    assign depth_ext = CMPW'(TABLE_DEPTH);
    assign cap_eff   = (cap_ext > depth_ext) ? depth_ext : cap_ext;

    assign stat.full       = (count_ext >= cap_eff);
    assign stat.idx_bad    = (idx_ext >= count_ext);
    assign stat.idx_last   = ((idx_ext + CMPW'(1)) == count_ext);
    assign stat.empty      = (count_reg == '0);
    assign stat.data_ge    = (ram_rdata >= item_reg);
    assign stat.ptr_is_one = (ptr_reg == CW'(1));
    assign stat.rem_more   = ((CMPW'(ptr_reg) + CMPW'(2)) < count_ext);

    always_comb
    begin
        ram_re = 1'b1;
        case (ctrl.rd_sel)
            RD_COUNT_M1: rd_ptr = count_reg - CW'(1);
            RD_PTR_M2:   rd_ptr = ptr_reg - CW'(2);
            RD_PTR_P2:   rd_ptr = ptr_reg + CW'(2);
            RD_INDEX:    rd_ptr = idx_cw;
            RD_INDEX_P1: rd_ptr = idx_cw + CW'(1);
            default:
            begin
                rd_ptr = ptr_reg;
                ram_re = 1'b0;
            end
        endcase
    end

    assign ram_raddr = AW'(rd_ptr);
    assign ram_waddr = AW'(ptr_reg);
    assign ram_wdata = ctrl.wr_item ? item_reg : ram_rdata;

    sat_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ctrl.wr_en),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        case (ctrl.ptr_op)
            PTR_COUNT: ptr_next = count_reg;
            PTR_INDEX: ptr_next = idx_cw;
            PTR_DEC:   ptr_next = ptr_reg - CW'(1);
            PTR_INC:   ptr_next = ptr_reg + CW'(1);
            default:   ptr_next = ptr_reg;
        endcase
    end

    always_comb
    begin
        case (ctrl.cnt_op)
            CNT_INC: count_next = count_reg + CW'(1);
            CNT_DEC: count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= CAP_RESET;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            count_reg <= count_next;
            done_reg  <= ctrl.respond;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (ctrl.latch)
        begin
            item_reg <= item_value;
        end
        if (ctrl.respond)
        begin
            status_reg     <= ctrl.resp_status;
            read_value_reg <= ctrl.resp_value ? ram_rdata : '0;
        end
    end

    assign done        = done_reg;
    assign read_value  = read_value_reg;
    assign status      = status_reg;
    assign entry_count = CNT_OUT_W'(count_reg);

endmodule

/* src/sorted_array_table_core.sv */
// sorted array table: one transaction at a time
// full insert, bad index, unused command, remove of last entry: done the next cycle
// lookup: reads the entry; insert: shifts each entry >= item up, then stores the item
// remove: moves each entry after the index down one place
// one ram port pair sets the rate: one entry moved per cycle; busy is high meanwhile
// async active-low reset empties the table and sets capacity to 256, no clearing pass
module sorted_array_table_core #(
    parameter int TABLE_DEPTH = sat_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = sat_pkg::VALUE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [sat_pkg::CAP_W-1:0]      cfg_wr_data,
    input  logic                           start,
    output logic                           busy,
    input  logic [sat_pkg::CMD_W-1:0]      command,
    input  logic [VALUE_WIDTH-1:0]         item_value,
    input  logic [sat_pkg::IDX_W-1:0]      entry_index,
    output logic                           done,
    output logic [VALUE_WIDTH-1:0]         read_value,
    output logic [sat_pkg::STATUS_W-1:0]   status,
    output logic [sat_pkg::CNT_OUT_W-1:0]  entry_count
);

    import sat_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    sat_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (stat),
        .ctrl    (ctrl),
        .busy    (busy)
    );

    sat_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_value  (item_value),
        .entry_index (entry_index),
        .ctrl        (ctrl),
        .stat        (stat),
        .done        (done),
        .read_value  (read_value),
        .status      (status),
        .entry_count (entry_count)
    );

endmodule

/* src/sat_checker.sv */
// port-level checks for the sorted array table, bound to the top level
module sat_checker #(
    parameter int TABLE_DEPTH = sat_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = sat_pkg::VALUE_WIDTH_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic [sat_pkg::CMD_W-1:0]      command,
    input logic [sat_pkg::IDX_W-1:0]      entry_index,
    input logic                           done,
    input logic [VALUE_WIDTH-1:0]         read_value,
    input logic [sat_pkg::STATUS_W-1:0]   status,
    input logic [sat_pkg::CNT_OUT_W-1:0]  entry_count
);

    import sat_pkg::*;

    // an accepted transaction either finishes at once or keeps the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted transaction neither busy nor done");

    // count only moves together with a result
    assert property (@(posedge clk) disable iff (!rst_n)
        !done |-> (entry_count == $past(entry_count)))
        else $error("entry count changed without a result");

    // failed commands return zero data
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_DONE) |-> (read_value == '0))
        else $error("nonzero read value on failed command");

    // lookup past the count reports a bad index
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == CMD_LOOKUP
            && CNT_OUT_W'(entry_index) >= entry_count)
        |=> (done && status == ST_BAD_INDEX))
        else $error("bad lookup index not flagged");

    // count never exceeds the table depth
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (int'(entry_count) <= TABLE_DEPTH))
        else $error("entry count beyond table depth");

endmodule

bind sorted_array_table_core sat_checker #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
) u_sat_checker (.*);

/* bench/tb.sv */
// testbench for sorted_array_table_core: directed table, then random command phases
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sat_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam int VW = VALUE_WIDTH_DEF;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int DRAIN_CYCLES = 300;
    localparam int N_DIR = 29;
    localparam int N_PHASES = 8;

    typedef struct packed {
        logic [VW-1:0]        read_value;
        logic [STATUS_W-1:0]  status;
        logic [CNT_OUT_W-1:0] entry_count;
    } table_result_t;

    typedef enum logic {
        ROW_CMD,
        ROW_CAP
    } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [CAP_W-1:0]   cap;
        logic [CMD_W-1:0]   op;
        logic [VW-1:0]      val;
        logic [IDX_W-1:0]   idx;
        logic               fixed;
        table_result_t      want;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CAP_W-1:0]     cfg_wr_data;
    logic                 start;
    logic                 busy;
    logic [CMD_W-1:0]     command;
    logic [VW-1:0]        item_value;
    logic [IDX_W-1:0]     entry_index;
    logic                 done;
    logic [VW-1:0]        read_value;
    logic [STATUS_W-1:0]  status;
    logic [CNT_OUT_W-1:0] entry_count;

    // model of the table contents and capacity register
    logic [VW-1:0]        sorted_vals [DEPTH];
    int                   held_entries = 0;
    logic [CAP_W-1:0]     capacity_reg = CAP_RESET;

    table_result_t        pending_results [$];
    stim_row_t            stim_table [N_DIR];
    int                   err_count = 0;
    int                   cycle_count = 0;
    bit                   idle_on = 1'b1;

    sorted_array_table_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .item_value  (item_value),
        .entry_index (entry_index),
        .done        (done),
        .read_value  (read_value),
        .status      (status),
        .entry_count (entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic table_result_t apply_command(input logic [CMD_W-1:0] op,
                                                    input logic [VW-1:0] val,
                                                    input logic [IDX_W-1:0] idx);
        table_result_t res;
        int cap_eff;
        int pos;
        int k;
        res.read_value = '0;
        res.status = ST_DONE;
        cap_eff = (int'(capacity_reg) > DEPTH) ? DEPTH : int'(capacity_reg);
        case (op)
            CMD_INSERT:
            begin
                if (held_entries >= cap_eff)
                    res.status = ST_FULL;
                else
                begin
                    pos = 0;
                    while (pos < held_entries && sorted_vals[pos] < val)
                        pos++;
                    for (k = held_entries; k > pos; k--)
                        sorted_vals[k] = sorted_vals[k-1];
                    sorted_vals[pos] = val;
                    held_entries++;
                end
            end
            CMD_LOOKUP:
            begin
                if (int'(idx) >= held_entries)
                    res.status = ST_BAD_INDEX;
                else
                    res.read_value = sorted_vals[idx];
            end
            CMD_REMOVE:
            begin
                if (int'(idx) >= held_entries)
                    res.status = ST_BAD_INDEX;
                else
                begin
                    for (k = int'(idx); k + 1 < held_entries; k++)
                        sorted_vals[k] = sorted_vals[k+1];
                    held_entries--;
                end
            end
            default: ;
        endcase
        res.entry_count = CNT_OUT_W'(held_entries);
        return res;
    endfunction

    function automatic stim_row_t row_chk(input logic [CMD_W-1:0] op, input logic [VW-1:0] val,
                                          input logic [IDX_W-1:0] idx);
        stim_row_t r;
        r = '0;
        r.kind = ROW_CMD;
        r.op = op;
        r.val = val;
        r.idx = idx;
        return r;
    endfunction

    function automatic stim_row_t row_fix(input logic [CMD_W-1:0] op, input logic [VW-1:0] val,
                                          input logic [IDX_W-1:0] idx, input logic [VW-1:0] rv,
                                          input logic [STATUS_W-1:0] st,
                                          input logic [CNT_OUT_W-1:0] cnt);
        stim_row_t r;
        r = row_chk(op, val, idx);
        r.fixed = 1'b1;
        r.want.read_value = rv;
        r.want.status = st;
        r.want.entry_count = cnt;
        return r;
    endfunction

    function automatic stim_row_t row_cap(input logic [CAP_W-1:0] cap);
        stim_row_t r;
        r = '0;
        r.kind = ROW_CAP;
        r.cap = cap;
        return r;
    endfunction

    // one transaction: optional idle gap, then hold start until accepted
    task automatic issue(input logic [CMD_W-1:0] op, input logic [VW-1:0] val,
                         input logic [IDX_W-1:0] idx, input logic fixed,
                         input table_result_t want);
        int gap;
        table_result_t predicted;
        gap = idle_on ? $urandom_range(0, 14) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        command <= op;
        item_value <= val;
        entry_index <= idx;
        do
            @(posedge clk);
        while (busy);
        predicted = apply_command(op, val, idx);
        pending_results.push_back(fixed ? want : predicted);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= cap;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        capacity_reg = cap;
    endtask

    always @(posedge clk)
    begin : check_results
        table_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no transaction pending");
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (read_value !== want.read_value)
                begin
                    $error("read_value: expected %h, got %h", want.read_value, read_value);
                    err_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    err_count++;
                end
                if (entry_count !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d", want.entry_count, entry_count);
                    err_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        logic [CMD_W-1:0] op;
        logic [VW-1:0]    val;
        logic [IDX_W-1:0] idx;
        logic [CAP_W-1:0] cap;
        int               n_items;
        int               ins_pct;
        int               r;
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        start <= 1'b0;
        command <= CMD_INSERT;
        item_value <= '0;
        entry_index <= '0;

        stim_table = '{
            row_fix(CMD_LOOKUP, 32'd0, 8'd0, 32'd0, ST_BAD_INDEX, 9'd0),
            row_fix(CMD_REMOVE, 32'd0, 8'd255, 32'd0, ST_BAD_INDEX, 9'd0),
            row_fix(CMD_UNUSED, 32'hFFFF_FFFF, 8'hFF, 32'd0, ST_DONE, 9'd0),
            row_fix(CMD_INSERT, 32'hFFFF_FFFF, 8'd0, 32'd0, ST_DONE, 9'd1),
            row_fix(CMD_INSERT, 32'd0, 8'd0, 32'd0, ST_DONE, 9'd2),
            row_chk(CMD_INSERT, 32'd5, 8'd0),
            row_chk(CMD_INSERT, 32'd5, 8'd0),
            row_fix(CMD_LOOKUP, 32'd0, 8'd0, 32'd0, ST_DONE, 9'd4),
            row_fix(CMD_LOOKUP, 32'd0, 8'd3, 32'hFFFF_FFFF, ST_DONE, 9'd4),
            row_fix(CMD_LOOKUP, 32'd0, 8'd4, 32'd0, ST_BAD_INDEX, 9'd4),
            row_chk(CMD_REMOVE, 32'd0, 8'd1),
            row_fix(CMD_LOOKUP, 32'd0, 8'd255, 32'd0, ST_BAD_INDEX, 9'd3),
            row_cap(9'd3),
            row_fix(CMD_INSERT, 32'd7, 8'd0, 32'd0, ST_FULL, 9'd3),
            row_cap(9'd0),
            row_fix(CMD_INSERT, 32'd1, 8'd0, 32'd0, ST_FULL, 9'd3),
            row_chk(CMD_REMOVE, 32'd0, 8'd0),
            row_fix(CMD_INSERT, 32'd1, 8'd0, 32'd0, ST_FULL, 9'd2),
            row_cap(9'd1),
            row_fix(CMD_INSERT, 32'd9, 8'd0, 32'd0, ST_FULL, 9'd2),
            row_chk(CMD_REMOVE, 32'd0, 8'd1),
            row_chk(CMD_REMOVE, 32'd0, 8'd0),
            row_fix(CMD_INSERT, 32'd42, 8'd0, 32'd0, ST_DONE, 9'd1),
            row_fix(CMD_INSERT, 32'd43, 8'd0, 32'd0, ST_FULL, 9'd1),
            row_cap(9'd511),
            row_chk(CMD_INSERT, 32'd43, 8'd0),
            row_fix(CMD_UNUSED, 32'h1234_5678, 8'd7, 32'd0, ST_DONE, 9'd2),
            row_cap(9'd256),
            row_chk(CMD_LOOKUP, 32'd0, 8'd1)
        };

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        foreach (stim_table[i])
        begin
            if (stim_table[i].kind == ROW_CAP)
                write_capacity(stim_table[i].cap);
            else
                issue(stim_table[i].op, stim_table[i].val, stim_table[i].idx,
                      stim_table[i].fixed, stim_table[i].want);
        end

        // phases: fill, fill to the top, capacity below count, drain, small tables, random capacity
        for (int p = 0; p < N_PHASES; p++)
        begin
            case (p)
                0: begin cap = 9'd256; n_items = 250; ins_pct = 55; end
                1: begin cap = 9'd511; n_items = 420; ins_pct = 85; end
                2: begin cap = 9'd3;   n_items = 200; ins_pct = 20; end
                3: begin cap = 9'd1;   n_items = 250; ins_pct = 10; end
                4: begin cap = 9'($urandom_range(1, 16)); n_items = 250; ins_pct = 50; end
                5: begin cap = 9'd0;   n_items = 100; ins_pct = 40; end
                6: begin cap = 9'd2;   n_items = 150; ins_pct = 50; end
                default: begin cap = 9'($urandom_range(1, 511)); n_items = 380; ins_pct = 55; end
            endcase
            write_capacity(cap);
            for (int n = 0; n < n_items; n++)
            begin
                if ($urandom_range(0, 39) == 0)
                    idle_on = !idle_on;
                r = $urandom_range(0, 99);
                if (r < ins_pct)
                    op = CMD_INSERT;
                else if (r >= 97)
                    op = CMD_UNUSED;
                else if ($urandom_range(0, 2) == 0)
                    op = CMD_LOOKUP;
                else
                    op = CMD_REMOVE;

                case ($urandom_range(0, 3))
                    0: val = $urandom;
                    1: val = VW'($urandom_range(0, 15));
                    2: val = (held_entries > 0) ?
                             sorted_vals[$urandom_range(0, held_entries - 1)] : $urandom;
                    default:
                    begin
                        case ($urandom_range(0, 3))
                            0: val = '0;
                            1: val = '1;
                            2: val = 32'h7FFF_FFFF;
                            default: val = 32'h8000_0000;
                        endcase
                    end
                endcase

                if (held_entries > 0 && $urandom_range(0, 9) < 8)
                    idx = IDX_W'($urandom_range(0, held_entries - 1));
                else
                    idx = IDX_W'($urandom_range(0, 255));

                issue(op, val, idx, 1'b0, '0);
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
src/sat_pkg.sv
src/sat_ram.sv
src/sat_ctrl.sv
src/sat_datapath.sv
src/sorted_array_table_core.sv
src/sat_checker.sv
bench/tb.sv
